FILE: rtl/plte_pkg.sv
`default_nettype none

package plte_pkg;

    localparam int          GAP_W          = 30;
    localparam int          LINE_W         = 31;
    localparam int          CHUNK_MAX      = 127;
    localparam int          SHORT_DELTA    = 64;
    localparam int          LONG_BYTES     = 5;
    localparam logic [7:0]  PAD_BYTE       = 8'd129;
    localparam logic [7:0]  CHUNK_FULL     = 8'd255;
    localparam logic [7:0]  LONG_MARK      = 8'd0;
    localparam logic [31:0] NEG_WORD_BYTES = 32'hFFFF_FFFC;

    localparam logic        CMD_RECORD     = 1'b0;
    localparam logic        CMD_FINISH     = 1'b1;

    localparam logic        REG_TEXT_BASE  = 1'b0;

    typedef enum logic [2:0] {
        ALU_PC_GAP,
        ALU_LIMIT,
        ALU_CHUNK,
        ALU_LINE,
        ALU_NEXT_PC
    } plte_alu_op_t;

    typedef struct packed {
        plte_alu_op_t      op;
        logic [31:0]       pc;
        logic [31:0]       prev_pc;
        logic [GAP_W-1:0]  gap;
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] prev_line;
    } plte_alu_in_t;

    typedef struct packed {
        logic [31:0] diff;
        logic        borrow;
    } plte_alu_out_t;

endpackage

`default_nettype wire

FILE: rtl/plte_alu.sv
`default_nettype none

module plte_alu #(
    parameter int MAX_PC_CHUNKS = 58
) (
    input  plte_pkg::plte_alu_in_t  alu_in,
    output plte_pkg::plte_alu_out_t alu_out
);

    localparam int          GapLimit  = MAX_PC_CHUNKS * plte_pkg::CHUNK_MAX;
    localparam logic [31:0] LIMIT     = 32'(GapLimit);

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [32:0] sum;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (alu_in.op)
            plte_pkg::ALU_PC_GAP: begin
                op_a = alu_in.pc;
                op_b = alu_in.prev_pc;
            end
            plte_pkg::ALU_LIMIT: begin
                op_a = LIMIT;
                op_b = {2'b00, alu_in.gap};
            end
            plte_pkg::ALU_CHUNK: begin
                op_a = {2'b00, alu_in.gap};
                op_b = 32'(plte_pkg::CHUNK_MAX);
            end
            plte_pkg::ALU_LINE: begin
                op_a = {1'b0, alu_in.line};
                op_b = {1'b0, alu_in.prev_line};
            end
            plte_pkg::ALU_NEXT_PC: begin
                op_a = alu_in.pc;
                op_b = plte_pkg::NEG_WORD_BYTES;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        sum = {1'b0, op_a} - {1'b0, op_b};
    end

    assign alu_out.diff   = sum[31:0];
    assign alu_out.borrow = sum[32];

endmodule

`default_nettype wire

FILE: rtl/pc_line_table_encoder.sv
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   64+2   tdata: pc, line; tuser: cmd, is_marker
// m_axis    out  8+1+1  tdata: code_byte; tlast: last; tuser: error
// apb       in   32     text_base at byte address 0
//
// One subtractor is shared over the gap, limit, chunk, line and next-pc steps.
// An encoded record runs gap, limit check, pc chunk bytes, line delta, next pc
// and 1 or 5 line bytes; a skipped record or a finish without padding stays idle.
// Each byte waits for the output register; m_axis_tready low stalls the sequencer.
// aresetn is synchronous: state, prev_pc, prev_line, size_odd, text_base, m_valid go to zero.
module pc_line_table_encoder #(
    parameter int MAX_PC_CHUNKS = 58
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] pc, [62:32] line, [63] zero
    input  logic [1:0]  s_axis_tuser,   // [0] cmd, [1] is_marker

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] code_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] error

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP,
        ST_CHECK,
        ST_ERR,
        ST_CHUNK,
        ST_DELTA,
        ST_NEXT_PC,
        ST_LINE,
        ST_PAD
    } state_t;

    state_t                          state_reg, state_next;
    logic [31:0]                     text_base_reg, text_base_next;
    logic [31:0]                     prev_pc_reg, prev_pc_next;
    logic [plte_pkg::LINE_W-1:0]     prev_line_reg, prev_line_next;
    logic                            size_odd_reg, size_odd_next;
    logic [31:0]                     pc_reg, pc_next;
    logic [plte_pkg::LINE_W-1:0]     line_reg, line_next;
    logic [plte_pkg::GAP_W-1:0]      gap_reg, gap_next;
    logic [31:0]                     delta_reg, delta_next;
    logic [2:0]                      idx_reg, idx_next;
    logic                            m_valid_reg, m_valid_next;
    logic [7:0]                      m_byte_reg, m_byte_next;
    logic                            m_last_reg, m_last_next;
    logic                            m_err_reg, m_err_next;

    plte_pkg::plte_alu_in_t  alu_in;
    plte_pkg::plte_alu_out_t alu_out;

    logic       slot_free;
    logic       in_fire;
    logic       cfg_wr;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       emit_err;
    logic       delta_pos;
    logic       delta_neg;
    logic [7:0] long_byte;

    plte_alu #(
        .MAX_PC_CHUNKS(MAX_PC_CHUNKS)
    ) u_alu (
        .alu_in (alu_in),
        .alu_out(alu_out)
    );

    assign slot_free = !m_valid_reg || m_axis_tready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == plte_pkg::REG_TEXT_BASE);

    assign delta_pos = (delta_reg[31:7] == '0) &&
                       (delta_reg[6:0] <= 7'(plte_pkg::SHORT_DELTA));
    assign delta_neg = &delta_reg[31:6];

    always_comb begin
        case (idx_reg)
            3'd0:    long_byte = plte_pkg::LONG_MARK;
            3'd1:    long_byte = delta_reg[31:24];
            3'd2:    long_byte = delta_reg[23:16];
            3'd3:    long_byte = delta_reg[15:8];
            default: long_byte = delta_reg[7:0];
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        text_base_next = text_base_reg;
        prev_pc_next   = prev_pc_reg;
        prev_line_next = prev_line_reg;
        size_odd_next  = size_odd_reg;
        pc_next        = pc_reg;
        line_next      = line_reg;
        gap_next       = gap_reg;
        delta_next     = delta_reg;
        idx_next       = idx_reg;
        emit           = 1'b0;
        emit_byte      = '0;
        emit_last      = 1'b0;
        emit_err       = 1'b0;

        alu_in.op        = plte_pkg::ALU_PC_GAP;
        alu_in.pc        = pc_reg;
        alu_in.prev_pc   = prev_pc_reg;
        alu_in.gap       = gap_reg;
        alu_in.line      = line_reg;
        alu_in.prev_line = prev_line_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser[0] == plte_pkg::CMD_FINISH) begin
                        if (size_odd_reg) begin
                            state_next = ST_PAD;
                        end
                    end else if (!s_axis_tuser[1] &&
                                 (s_axis_tdata[62:32] != prev_line_reg)) begin
                        pc_next    = s_axis_tdata[31:0];
                        line_next  = s_axis_tdata[62:32];
                        state_next = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                alu_in.op  = plte_pkg::ALU_PC_GAP;
                gap_next   = alu_out.diff[31:2];
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                alu_in.op  = plte_pkg::ALU_LIMIT;
                state_next = alu_out.borrow ? ST_ERR : ST_CHUNK;
            end
            ST_ERR: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_byte  = '0;
                    emit_last  = 1'b1;
                    emit_err   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CHUNK: begin
                alu_in.op = plte_pkg::ALU_CHUNK;
                if (gap_reg == '0) begin
                    state_next = ST_DELTA;
                end else if (slot_free) begin
                    emit          = 1'b1;
                    size_odd_next = !size_odd_reg;
                    if (alu_out.borrow) begin
                        emit_byte = {1'b1, gap_reg[6:0]};
                        gap_next  = '0;
                    end else begin
                        emit_byte = plte_pkg::CHUNK_FULL;
                        gap_next  = alu_out.diff[plte_pkg::GAP_W-1:0];
                    end
                end
            end
            ST_DELTA: begin
                alu_in.op      = plte_pkg::ALU_LINE;
                delta_next     = alu_out.diff;
                prev_line_next = line_reg;
                idx_next       = '0;
                state_next     = ST_NEXT_PC;
            end
            ST_NEXT_PC: begin
                alu_in.op    = plte_pkg::ALU_NEXT_PC;
                prev_pc_next = alu_out.diff;
                state_next   = ST_LINE;
            end
            ST_LINE: begin
                if (slot_free) begin
                    emit          = 1'b1;
                    size_odd_next = !size_odd_reg;
                    if (delta_pos) begin
                        emit_byte  = delta_reg[7:0];
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (delta_neg) begin
                        emit_byte  = 8'(plte_pkg::SHORT_DELTA) - delta_reg[7:0];
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        emit_byte = long_byte;
                        idx_next  = idx_reg + 3'd1;
                        if (idx_reg == 3'(plte_pkg::LONG_BYTES - 1)) begin
                            emit_last  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (slot_free) begin
                    emit          = 1'b1;
                    emit_byte     = plte_pkg::PAD_BYTE;
                    emit_last     = 1'b1;
                    size_odd_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            text_base_next = pwdata;
            prev_pc_next   = pwdata;
        end

        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = emit_byte;
            m_last_next  = emit_last;
            m_err_next   = emit_err;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            text_base_reg <= '0;
            prev_pc_reg   <= '0;
            prev_line_reg <= '0;
            size_odd_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            text_base_reg <= text_base_next;
            prev_pc_reg   <= prev_pc_next;
            prev_line_reg <= prev_line_next;
            size_odd_reg  <= size_odd_next;
            m_valid_reg   <= m_valid_next;
        end
        pc_reg     <= pc_next;
        line_reg   <= line_next;
        gap_reg    <= gap_next;
        delta_reg  <= delta_next;
        idx_reg    <= idx_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_byte_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_err_reg;
    assign prdata        = (paddr[2] == plte_pkg::REG_TEXT_BASE) ? text_base_reg : '0;
    assign pready        = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/plte_checker.sv
`default_nettype none

module plte_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    // reset empties the output and reopens the input
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty or input not ready after reset");

    // a rejection is a single zero word closing its item
    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("error word is not a lone zero word");

    // ready drops only right after an accepted input word
    a_busy_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input ready dropped without an accepted word");

    // hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("stalled output word changed");

endmodule

bind pc_line_table_encoder plte_checker u_plte_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int         CHUNK_MAX     = plte_pkg::CHUNK_MAX;
    localparam int         SHORT_DELTA   = plte_pkg::SHORT_DELTA;
    localparam logic [7:0] PAD_BYTE      = plte_pkg::PAD_BYTE;
    localparam logic [7:0] CHUNK_FULL    = plte_pkg::CHUNK_FULL;
    localparam logic [7:0] LONG_MARK     = plte_pkg::LONG_MARK;
    localparam logic       CMD_RECORD    = plte_pkg::CMD_RECORD;
    localparam logic       CMD_FINISH    = plte_pkg::CMD_FINISH;
    localparam logic       REG_TEXT_BASE = plte_pkg::REG_TEXT_BASE;

    localparam int         PC_CHUNKS  = 58;
    localparam int         MAX_GAP    = PC_CHUNKS * CHUNK_MAX;
    localparam logic [7:0] CHUNK_BASE = 8'd128;
    localparam int         PHASES     = 5;
    localparam int         PER_PHASE  = 40;
    localparam int         LIMIT      = 400000;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
        logic       err;
    } table_byte_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] pc;
        logic [30:0] ln;
        logic        mk;
        logic        typed;
        logic [2:0]  n;
        logic        err;
        logic [39:0] codes;
    } stim_row_t;

    localparam stim_row_t PLAN [21] = '{
        '{CMD_FINISH, 32'd0,     31'd0,          1'b0, 1'b1, 3'd0, 1'b0, 40'd0},
        '{CMD_RECORD, 32'd0,     31'd1,          1'b0, 1'b1, 3'd1, 1'b0, {8'd1, 32'd0}},
        '{CMD_RECORD, 32'd8,     31'd5,          1'b1, 1'b1, 3'd0, 1'b0, 40'd0},
        '{CMD_RECORD, 32'd8,     31'd1,          1'b0, 1'b1, 3'd0, 1'b0, 40'd0},
        '{CMD_FINISH, 32'd0,     31'd0,          1'b0, 1'b1, 3'd1, 1'b0, {PAD_BYTE, 32'd0}},
        '{CMD_RECORD, 32'd512,   31'd65,         1'b0, 1'b1, 3'd2, 1'b0,
          {CHUNK_FULL, 8'd64, 24'd0}},
        '{CMD_RECORD, 32'd1028,  31'd1,          1'b0, 1'b1, 3'd3, 1'b0,
          {CHUNK_FULL, 8'd129, 8'd128, 16'd0}},
        '{CMD_RECORD, 32'd1032,  31'd0,          1'b0, 1'b1, 3'd1, 1'b0, {8'd65, 32'd0}},
        '{CMD_RECORD, 32'd1039,  31'h7FFF_FFFF,  1'b0, 1'b1, 3'd5, 1'b0,
          {LONG_MARK, 32'h7FFF_FFFF}},
        '{CMD_RECORD, 32'd1043,  31'd0,          1'b0, 1'b1, 3'd5, 1'b0,
          {LONG_MARK, 32'h8000_0001}},
        '{CMD_RECORD, 32'd30511, 31'd65,         1'b0, 1'b0, 3'd0, 1'b0, 40'd0},
        '{CMD_RECORD, 32'd59983, 31'd1,          1'b0, 1'b1, 3'd1, 1'b1, {LONG_MARK, 32'd0}},
        '{CMD_RECORD, 32'd30511, 31'd2,          1'b0, 1'b1, 3'd1, 1'b1, {LONG_MARK, 32'd0}},
        '{CMD_RECORD, 32'd30515, 31'd1,          1'b0, 1'b1, 3'd1, 1'b0, {8'd128, 32'd0}},
        '{CMD_FINISH, 32'd0,     31'd0,          1'b1, 1'b1, 3'd0, 1'b0, 40'd0},
        '{CMD_RECORD, 32'd30519, 31'd2,          1'b0, 1'b1, 3'd1, 1'b0, {8'd1, 32'd0}},
        '{CMD_FINISH, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 3'd1, 1'b0,
          {PAD_BYTE, 32'd0}},
        '{CMD_RECORD, 32'hFFFF_FFFC, 31'd3,      1'b0, 1'b1, 3'd1, 1'b1, {LONG_MARK, 32'd0}},
        '{CMD_RECORD, 32'd30779, 31'd100,        1'b0, 1'b0, 3'd0, 1'b0, 40'd0},
        '{CMD_RECORD, 32'd30783, 31'd35,         1'b0, 1'b0, 3'd0, 1'b0, 40'd0},
        '{CMD_RECORD, 32'd30787, 31'd99,         1'b0, 1'b0, 3'd0, 1'b0, 40'd0}
    };

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // [31:0] pc, [62:32] line, [63] zero
    logic [1:0]  s_axis_tuser  = '0;   // [0] cmd, [1] is_marker
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] code_byte
    logic        m_axis_tlast;
    logic        m_axis_tuser;         // [0] error
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] base_reg;
    logic [31:0] base_pc;
    logic [30:0] last_line;
    logic        odd_len;
    table_byte_t staged [$];
    table_byte_t pending [$];
    int          fault_count = 0;
    int          cycles      = 0;
    bit          calm        = 1'b0;

    pc_line_table_encoder #(
        .MAX_PC_CHUNKS(PC_CHUNKS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    always @(posedge aclk) begin
        table_byte_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                note_fault($sformatf("unexpected word: byte %0d last %b error %b",
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser));
            end else begin
                want = pending.pop_front();
                if (want.code != m_axis_tdata || want.fin != m_axis_tlast ||
                    want.err != m_axis_tuser) begin
                    note_fault($sformatf(
                        "word mismatch: expected byte %0d last %b error %b, got %0d %b %b",
                        want.code, want.fin, want.err,
                        m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end
            end
        end
    end

    function automatic void put_code(input logic [7:0] code);
        staged.push_back('{code: code, fin: 1'b0, err: 1'b0});
        odd_len = ~odd_len;
    endfunction

    // compute the table bytes one input word produces and advance the encoder state
    function automatic void encode_word(input logic cmd, input logic [31:0] pc,
                                        input logic [30:0] ln, input logic mk);
        logic [31:0] gap;
        logic [31:0] part;
        logic [31:0] delta;
        logic [31:0] neg;
        staged.delete();
        if (cmd == CMD_FINISH) begin
            if (odd_len) put_code(PAD_BYTE);
        end else if (!mk && ln != last_line) begin
            gap = (pc - base_pc) >> 2;
            if (gap > 32'(MAX_GAP)) begin
                staged.push_back('{code: LONG_MARK, fin: 1'b0, err: 1'b1});
            end else begin
                while (gap != 0) begin
                    part = (gap < CHUNK_MAX) ? gap : 32'(CHUNK_MAX);
                    put_code(CHUNK_BASE + 8'(part));
                    gap = gap - part;
                end
                delta = {1'b0, ln} - {1'b0, last_line};
                neg = 32'd0 - delta;
                last_line = ln;
                base_pc = pc + 32'd4;
                if (delta >= 1 && delta <= SHORT_DELTA) begin
                    put_code(delta[7:0]);
                end else if (neg <= SHORT_DELTA) begin
                    put_code(8'(SHORT_DELTA) + neg[7:0]);
                end else begin
                    put_code(LONG_MARK);
                    put_code(delta[31:24]);
                    put_code(delta[23:16]);
                    put_code(delta[15:8]);
                    put_code(delta[7:0]);
                end
            end
        end
        if (staged.size() > 0) staged[$].fin = 1'b1;
    endfunction

    task automatic send_word(input logic cmd, input logic [31:0] pc,
                             input logic [30:0] ln, input logic mk);
        while (!calm && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ln, pc};
        s_axis_tuser  <= {mk, cmd};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        encode_word(cmd, pc, ln, mk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_base(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_TEXT_BASE) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        base_reg = value;
        base_pc  = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== base_reg)
            note_fault($sformatf("text_base readback: expected %h, got %h", base_reg, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_word(output int made);
        int unsigned pick;
        int unsigned g;
        int unsigned d;
        logic        cmd;
        logic        mk;
        logic [31:0] pc;
        logic [30:0] ln;
        pick = $urandom_range(99);
        cmd  = CMD_RECORD;
        mk   = 1'b0;
        pc   = $urandom;
        ln   = 31'($urandom);
        if (pick < 6) begin
            cmd = CMD_FINISH;
            mk  = 1'($urandom);
        end else if (pick < 10) begin
            mk = 1'b1;
        end else if (pick >= 15) begin
            g = $urandom_range(99);
            if (g < 40)
                pc = base_pc + 32'($urandom_range(3)) * 4;
            else if (g < 70)
                pc = base_pc + 32'($urandom_range(200, 4)) * 4;
            else if (g < 85)
                pc = base_pc + 32'($urandom_range(MAX_GAP, 201)) * 4;
            else if (g < 93)
                pc = base_pc + 32'(MAX_GAP + $urandom_range(1)) * 4;
            else
                pc = base_pc - 32'($urandom_range(1000, 1)) * 4;
            pc = pc + 32'($urandom_range(3));
            d = $urandom_range(99);
            if (d < 35)
                ln = last_line + 31'($urandom_range(64, 1));
            else if (d < 60)
                ln = last_line - 31'($urandom_range(64, 1));
            else if (d < 68)
                ln = last_line;
            else if (d < 74)
                ln = last_line + 31'($urandom_range(1000, 65));
            else if (d < 80)
                ln = last_line - 31'($urandom_range(1000, 65));
        end
        send_word(cmd, pc, ln, mk);
        made = staged.size();
        foreach (staged[k]) pending.push_back(staged[k]);
    endtask

    initial begin
        logic [31:0] bases [PHASES];
        stim_row_t   row;
        int          made;
        int          counted;
        base_reg  = '0;
        base_pc   = '0;
        last_line = '0;
        odd_len   = 1'b0;
        bases = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFC, $urandom, $urandom};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(PLAN); i++) begin
            row = PLAN[i];
            send_word(row.cmd, row.pc, row.ln, row.mk);
            if (row.typed) begin
                for (int j = 0; j < row.n; j++) begin
                    pending.push_back('{code: row.codes[39 - 8 * j -: 8],
                                        fin: (j == row.n - 1), err: row.err});
                end
            end else begin
                foreach (staged[k]) pending.push_back(staged[k]);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_base(bases[p]);
            calm = (p == 2);
            counted = 0;
            while (counted < PER_PHASE) begin
                random_word(made);
                if (made > 0) counted++;
            end
        end
        calm = 1'b0;

        settle();
        repeat (20) @(posedge aclk);
        if (fault_count == 0 && pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
